/* rtl/touch_and_input_frame_parser_macros.svh */
// assertion macros for the touch and input frame parser
`ifndef TOUCH_AND_INPUT_FRAME_PARSER_MACROS_SVH
`define TOUCH_AND_INPUT_FRAME_PARSER_MACROS_SVH

// implication in the same cycle, checked outside reset
`define TIFP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication in the next cycle, checked outside reset
`define TIFP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/tifp_pkg.sv */
// shared constants and types of the touch and input frame parser
package tifp_pkg;

    localparam int PAYLOAD_DEPTH = 32;
    localparam int IDX_W         = $clog2(PAYLOAD_DEPTH);
    localparam int CNT_W         = $clog2(PAYLOAD_DEPTH + 1);

    localparam int JOBQ_DEPTH    = 2;
    localparam int JOBQ_PTR_W    = $clog2(JOBQ_DEPTH);
    localparam int JOBQ_CNT_W    = $clog2(JOBQ_DEPTH + 1);

    localparam int PADDR_W       = 3;
    localparam int PDATA_W       = 32;

    localparam logic REG_TOUCH_EN = 1'b0;
    localparam logic REG_INPUT_EN = 1'b1;

    localparam logic [7:0] TOUCH_HEAD  = 8'hFE;
    localparam logic [7:0] FRAME_TAIL  = 8'hFF;
    localparam logic [7:0] INPUT_HEAD0 = 8'h04;
    localparam logic [7:0] INPUT_HEAD1 = 8'h11;
    localparam logic [7:0] INPUT_END   = 8'h00;

    localparam logic [1:0] KIND_TOUCH   = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_EMPTY   = 2'd2;

    typedef enum logic [1:0] {
        IK_NONE  = 2'd0,
        IK_RUN   = 2'd1,
        IK_EMPTY = 2'd2
    } t_ikind;

    typedef struct packed {
        logic             touch;
        logic [7:0]       t0;
        logic [7:0]       t1;
        t_ikind           ikind;
        logic [CNT_W-1:0] count;
    } t_job;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        logic [7:0]       data;
    } t_mem_wr;

    typedef struct packed {
        logic run_done;
    } t_back_stat;

endpackage

/* rtl/tifp_front.sv */
// front end: both frame recognizers, payload writes and report jobs
module tifp_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [7:0]        i_rx_byte,
    output logic              o_full,
    input  logic              i_touch_en,
    input  logic              i_input_en,
    input  logic              i_q_full,
    output logic              o_q_push,
    output tifp_pkg::t_job    o_job,
    output tifp_pkg::t_mem_wr o_mem_wr,
    input  tifp_pkg::t_back_stat i_back_stat
);
    import tifp_pkg::*;

    typedef enum logic [2:0] {
        T_WAIT_HEAD = 3'b001,
        T_DATA      = 3'b010,
        T_WAIT_TAIL = 3'b100
    } t_touch_state;

    typedef enum logic [3:0] {
        I_WAIT_HEAD0 = 4'b0001,
        I_WAIT_HEAD1 = 4'b0010,
        I_PAYLOAD    = 4'b0100,
        I_WAIT_TAIL  = 4'b1000
    } t_input_state;

    t_touch_state     r_t_state, n_t_state;
    logic             r_t_cnt, n_t_cnt;
    logic [7:0]       r_t0, n_t0;
    logic [7:0]       r_t1, n_t1;
    t_input_state     r_i_state, n_i_state;
    logic [CNT_W-1:0] r_i_cnt, n_i_cnt;
    logic             r_lock, n_lock;

    logic             accept;
    logic             touch_ev;
    t_ikind           ikind;

    assign o_full = i_q_full || r_lock;
    assign accept = i_push && !o_full;

    always_comb begin
        n_t_state = r_t_state;
        n_t_cnt   = r_t_cnt;
        n_t0      = r_t0;
        n_t1      = r_t1;
        touch_ev  = 1'b0;
        if (accept) begin
            case (r_t_state)
                T_WAIT_HEAD: begin
                    if (i_rx_byte == TOUCH_HEAD) begin
                        n_t_state = T_DATA;
                        n_t_cnt   = 1'b0;
                    end
                end
                T_DATA: begin
                    if (!r_t_cnt) begin
                        n_t0    = i_rx_byte;
                        n_t_cnt = 1'b1;
                    end else begin
                        n_t1      = i_rx_byte;
                        n_t_cnt   = 1'b0;
                        n_t_state = T_WAIT_TAIL;
                    end
                end
                T_WAIT_TAIL: begin
                    touch_ev  = (i_rx_byte == FRAME_TAIL) && i_touch_en;
                    n_t_state = T_WAIT_HEAD;
                end
                default: n_t_state = T_WAIT_HEAD;
            endcase
        end
    end

    always_comb begin
        n_i_state = r_i_state;
        n_i_cnt   = r_i_cnt;
        ikind     = IK_NONE;
        o_mem_wr  = '{en: 1'b0, addr: r_i_cnt[IDX_W-1:0], data: i_rx_byte};
        if (accept) begin
            case (r_i_state)
                I_WAIT_HEAD0: begin
                    if (i_rx_byte == INPUT_HEAD0) begin
                        n_i_state = I_WAIT_HEAD1;
                    end
                end
                I_WAIT_HEAD1: begin
                    if (i_rx_byte == INPUT_HEAD1) begin
                        n_i_state = I_PAYLOAD;
                        n_i_cnt   = '0;
                    end else begin
                        n_i_state = I_WAIT_HEAD0;
                    end
                end
                I_PAYLOAD: begin
                    if (i_rx_byte == INPUT_END) begin
                        n_i_state = I_WAIT_TAIL;
                    end else if (r_i_cnt < CNT_W'(PAYLOAD_DEPTH)) begin
                        o_mem_wr.en = 1'b1;
                        n_i_cnt     = r_i_cnt + 1'b1;
                    end else begin
                        n_i_state = I_WAIT_HEAD0;
                    end
                end
                I_WAIT_TAIL: begin
                    if (i_rx_byte == FRAME_TAIL && i_input_en) begin
                        ikind = (r_i_cnt == '0) ? IK_EMPTY : IK_RUN;
                    end
                    n_i_state = I_WAIT_HEAD0;
                end
                default: n_i_state = I_WAIT_HEAD0;
            endcase
        end
    end

    assign o_q_push = touch_ev || (ikind != IK_NONE);
    assign o_job    = '{touch: touch_ev, t0: r_t0, t1: r_t1, ikind: ikind, count: r_i_cnt};

    always_comb begin
        n_lock = r_lock;
        if (i_back_stat.run_done) begin
            n_lock = 1'b0;
        end
        if (ikind == IK_RUN) begin
            n_lock = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t_state <= T_WAIT_HEAD;
            r_t_cnt   <= 1'b0;
            r_i_state <= I_WAIT_HEAD0;
            r_i_cnt   <= '0;
            r_lock    <= 1'b0;
        end else begin
            r_t_state <= n_t_state;
            r_t_cnt   <= n_t_cnt;
            r_i_state <= n_i_state;
            r_i_cnt   <= n_i_cnt;
            r_lock    <= n_lock;
        end
    end

    always_ff @(posedge i_clk) begin
        r_t0 <= n_t0;
        r_t1 <= n_t1;
    end

endmodule

/* rtl/tifp_job_q.sv */
// short queue of report jobs between front and back end
module tifp_job_q (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tifp_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output tifp_pkg::t_job o_job,
    output logic           o_empty
);
    import tifp_pkg::*;

    t_job                  r_entry [JOBQ_DEPTH];
    logic [JOBQ_PTR_W-1:0] r_wr_ptr;
    logic [JOBQ_PTR_W-1:0] r_rd_ptr;
    logic [JOBQ_CNT_W-1:0] r_count;
    logic                  do_push;
    logic                  do_pop;

    assign o_full  = (r_count == JOBQ_CNT_W'(JOBQ_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_entry[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wr_ptr] <= i_job;
        end
    end

endmodule

/* rtl/tifp_back.sv */
// back end: payload store and result sequencer with output register
module tifp_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  tifp_pkg::t_job              i_job,
    input  logic                        i_job_empty,
    output logic                        o_job_pop,
    input  tifp_pkg::t_mem_wr           i_mem_wr,
    output tifp_pkg::t_back_stat        o_back_stat,
    input  logic                        i_pop,
    output logic                        o_empty,
    output logic [1:0]                  o_report_kind,
    output logic [7:0]                  o_touch_first,
    output logic [7:0]                  o_touch_second,
    output logic [7:0]                  o_payload_byte,
    output logic [tifp_pkg::IDX_W-1:0]  o_payload_position,
    output logic [tifp_pkg::CNT_W-1:0]  o_payload_count,
    output logic                        o_run_last
);
    import tifp_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_TOUCH = 4'b0010,
        S_RUN   = 4'b0100,
        S_EMPTY = 4'b1000
    } t_back_state;

    logic [7:0]       r_mem [PAYLOAD_DEPTH];
    logic [7:0]       r_rd_data;

    t_back_state      r_state, n_state;
    t_job             r_job, n_job;
    logic [IDX_W-1:0] r_idx, n_idx;

    logic             r_out_valid, n_out_valid;
    logic [1:0]       r_kind, n_kind;
    logic [7:0]       r_t0, n_t0;
    logic [7:0]       r_t1, n_t1;
    logic [7:0]       r_pb, n_pb;
    logic [IDX_W-1:0] r_pos, n_pos;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_last, n_last;

    logic             out_free;
    logic             run_end;

    assign out_free = !r_out_valid || i_pop;
    assign run_end  = ((CNT_W'(r_idx) + 1'b1) == r_job.count);

    always_comb begin
        n_state     = r_state;
        n_job       = r_job;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && !i_pop;
        n_kind      = r_kind;
        n_t0        = r_t0;
        n_t1        = r_t1;
        n_pb        = r_pb;
        n_pos       = r_pos;
        n_cnt       = r_cnt;
        n_last      = r_last;
        o_job_pop   = 1'b0;
        o_back_stat = '{run_done: 1'b0};
        case (r_state)
            S_IDLE: begin
                if (!i_job_empty) begin
                    o_job_pop = 1'b1;
                    n_job     = i_job;
                    n_idx     = '0;
                    if (i_job.touch) begin
                        n_state = S_TOUCH;
                    end else if (i_job.ikind == IK_RUN) begin
                        n_state = S_RUN;
                    end else begin
                        n_state = S_EMPTY;
                    end
                end
            end
            S_TOUCH: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_kind      = KIND_TOUCH;
                    n_t0        = r_job.t0;
                    n_t1        = r_job.t1;
                    n_pb        = '0;
                    n_pos       = '0;
                    n_cnt       = '0;
                    n_last      = (r_job.ikind == IK_NONE);
                    case (r_job.ikind)
                        IK_RUN:   n_state = S_RUN;
                        IK_EMPTY: n_state = S_EMPTY;
                        default:  n_state = S_IDLE;
                    endcase
                end
            end
            S_RUN: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_kind      = KIND_PAYLOAD;
                    n_t0        = '0;
                    n_t1        = '0;
                    n_pb        = r_rd_data;
                    n_pos       = r_idx;
                    n_cnt       = r_job.count;
                    n_last      = run_end;
                    if (run_end) begin
                        n_idx       = '0;
                        n_state     = S_IDLE;
                        o_back_stat = '{run_done: 1'b1};
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            S_EMPTY: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_kind      = KIND_EMPTY;
                    n_t0        = '0;
                    n_t1        = '0;
                    n_pb        = '0;
                    n_pos       = '0;
                    n_cnt       = '0;
                    n_last      = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // read data always follows the current run index
    always_ff @(posedge i_clk) begin
        if (i_mem_wr.en) begin
            r_mem[i_mem_wr.addr] <= i_mem_wr.data;
        end
        r_rd_data <= r_mem[n_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job  <= n_job;
        r_kind <= n_kind;
        r_t0   <= n_t0;
        r_t1   <= n_t1;
        r_pb   <= n_pb;
        r_pos  <= n_pos;
        r_cnt  <= n_cnt;
        r_last <= n_last;
    end

    assign o_empty            = !r_out_valid;
    assign o_report_kind      = r_kind;
    assign o_touch_first      = r_t0;
    assign o_touch_second     = r_t1;
    assign o_payload_byte     = r_pb;
    assign o_payload_position = r_pos;
    assign o_payload_count    = r_cnt;
    assign o_run_last         = r_last;

endmodule

/* rtl/touch_and_input_frame_parser.sv */
// top level of the touch and input frame parser
//
//  channel   direction  handshake             words
//  rx byte   in         push / full           i_rx_byte
//  report    out        empty / pop           o_report_kind .. o_run_last
//  config    in         psel penable pwrite   touch enable at 0, input enable at 4
//
// a byte is taken whenever push is high and the input is not held off
// a completed frame leaves as one word per cycle while the output is popped, up to 33 words after its closing ff
// the payload store has one read port: full stays high from a closing ff that starts
// a payload run until the last word of that run is in the output register
// the job queue holds two report jobs; a full queue or an unpopped word stalls only its side
// reset is synchronous and clears all control state and both enables
`include "touch_and_input_frame_parser_macros.svh"

module touch_and_input_frame_parser (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [7:0]                    i_rx_byte,
    output logic                          empty,
    input  logic                          pop,
    output logic [1:0]                    o_report_kind,
    output logic [7:0]                    o_touch_first,
    output logic [7:0]                    o_touch_second,
    output logic [7:0]                    o_payload_byte,
    output logic [tifp_pkg::IDX_W-1:0]    o_payload_position,
    output logic [tifp_pkg::CNT_W-1:0]    o_payload_count,
    output logic                          o_run_last,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tifp_pkg::PADDR_W-1:0]  paddr,
    input  logic [tifp_pkg::PDATA_W-1:0]  pwdata,
    output logic [tifp_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import tifp_pkg::*;

    logic       r_touch_en;
    logic       r_input_en;
    logic       cfg_wr;

    logic       q_push;
    logic       q_full;
    logic       q_pop;
    logic       q_empty;
    t_job       front_job;
    t_job       q_job;
    t_mem_wr    mem_wr;
    t_back_stat back_stat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_INPUT_EN) ? {{(PDATA_W-1){1'b0}}, r_input_en}
                                               : {{(PDATA_W-1){1'b0}}, r_touch_en};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_touch_en <= 1'b0;
            r_input_en <= 1'b0;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_TOUCH_EN) begin
                r_touch_en <= pwdata[0];
            end else begin
                r_input_en <= pwdata[0];
            end
        end
    end

    tifp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_rx_byte   (i_rx_byte),
        .o_full      (full),
        .i_touch_en  (r_touch_en),
        .i_input_en  (r_input_en),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_job       (front_job),
        .o_mem_wr    (mem_wr),
        .i_back_stat (back_stat)
    );

    tifp_job_q u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (front_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_job   (q_job),
        .o_empty (q_empty)
    );

    tifp_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_job              (q_job),
        .i_job_empty        (q_empty),
        .o_job_pop          (q_pop),
        .i_mem_wr           (mem_wr),
        .o_back_stat        (back_stat),
        .i_pop              (pop),
        .o_empty            (empty),
        .o_report_kind      (o_report_kind),
        .o_touch_first      (o_touch_first),
        .o_touch_second     (o_touch_second),
        .o_payload_byte     (o_payload_byte),
        .o_payload_position (o_payload_position),
        .o_payload_count    (o_payload_count),
        .o_run_last         (o_run_last)
    );

    `TIFP_ASSERT_NOW(a_pos_below_count, i_clk, i_rst_n, !empty && o_report_kind == KIND_PAYLOAD, CNT_W'(o_payload_position) < o_payload_count, "payload position not below count")
    `TIFP_ASSERT_NOW(a_run_end_pos, i_clk, i_rst_n, !empty && o_report_kind == KIND_PAYLOAD && o_run_last, (CNT_W'(o_payload_position) + 1'b1) == o_payload_count, "last payload word not at end of run")
    `TIFP_ASSERT_NOW(a_empty_is_last, i_clk, i_rst_n, !empty && o_report_kind == KIND_EMPTY, o_run_last, "empty frame word not marked last")
    `TIFP_ASSERT_NEXT(a_store_held, i_clk, i_rst_n, q_push && front_job.ikind == IK_RUN, full, "input not held off during payload run")

endmodule
